>>> hw/rtl/shadow_taint_tag_tracker_assert.svh
// assertion macros used by the tracker rtl
`ifndef SHADOW_TAINT_TAG_TRACKER_ASSERT_SVH
`define SHADOW_TAINT_TAG_TRACKER_ASSERT_SVH

// same-cycle implication
`define STT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/stt_pkg.sv
// shared constants, codes and types of the taint tag tracker
package stt_pkg;

   // depths are powers of two for the shadow store
   localparam int SHADOW_ENTRIES   = 65536;
   localparam int COMPARE_SITES    = 256;
   localparam int TRACKED_OFFSETS  = 4096;
   localparam int MAX_ACCESS_BYTES = 16;

   localparam int WORDS_PER_SITE = (TRACKED_OFFSETS + 63) / 64;
   localparam int MAP_WORDS      = COMPARE_SITES * WORDS_PER_SITE;

   localparam int CLR_COUNT_A = (SHADOW_ENTRIES > MAP_WORDS) ? SHADOW_ENTRIES : MAP_WORDS;
   localparam int CLR_COUNT   = (CLR_COUNT_A > COMPARE_SITES) ? CLR_COUNT_A : COMPARE_SITES;

   localparam int TAG_AW  = $clog2(SHADOW_ENTRIES);
   localparam int MAP_AW  = $clog2(MAP_WORDS);
   localparam int SITE_AW = $clog2(COMPARE_SITES);
   localparam int CLR_W   = $clog2(CLR_COUNT);
   localparam int CNT_W   = $clog2(MAX_ACCESS_BYTES + 1);

   localparam logic [15:0] SOURCE_OFFSET_LIMIT = 16'd65534;

   localparam logic [2:0] KIND_SOURCE  = 3'd0;
   localparam logic [2:0] KIND_LOAD    = 3'd1;
   localparam logic [2:0] KIND_STORE   = 3'd2;
   localparam logic [2:0] KIND_COMPARE = 3'd3;
   localparam logic [2:0] KIND_READOUT = 3'd4;

   typedef struct packed {
      logic              tag_we;
      logic [TAG_AW-1:0] tag_addr;
      logic [15:0]       tag_wdata;
      logic              map_we;
      logic [MAP_AW-1:0] map_addr;
      logic [63:0]       map_wdata;
      logic              hit_we;
      logic [SITE_AW-1:0] hit_addr;
      logic              hit_wdata;
   } mem_cmd_type;

   typedef struct packed {
      logic [15:0] tag_rdata;
      logic [63:0] map_rdata;
      logic        hit_rdata;
   } mem_rsp_type;

endpackage

>>> hw/rtl/stt_mem_bank.sv
// shadow tag, offset bitmap and hit flag memories
module stt_mem_bank
   import stt_pkg::*;
(
   input  logic        clock,
   input  mem_cmd_type cmd,
   output mem_rsp_type rsp
);

   logic [15:0] tag_mem [SHADOW_ENTRIES];
   logic [63:0] map_mem [MAP_WORDS];
   logic        hit_mem [COMPARE_SITES];

   logic [15:0] tag_rdata_ff;
   logic [63:0] map_rdata_ff;
   logic        hit_rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.tag_we) begin
         tag_mem[cmd.tag_addr] <= cmd.tag_wdata;
      end
      tag_rdata_ff <= tag_mem[cmd.tag_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.map_we) begin
         map_mem[cmd.map_addr] <= cmd.map_wdata;
      end
      map_rdata_ff <= map_mem[cmd.map_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.hit_we) begin
         hit_mem[cmd.hit_addr] <= cmd.hit_wdata;
      end
      hit_rdata_ff <= hit_mem[cmd.hit_addr];
   end

   assign rsp.tag_rdata = tag_rdata_ff;
   assign rsp.map_rdata = map_rdata_ff;
   assign rsp.hit_rdata = hit_rdata_ff;

endmodule

>>> hw/rtl/shadow_taint_tag_tracker.sv
// taint tag tracker top level: sequencer, clearing pass and memory bank
//
// A request is taken at a clock edge where start is high and busy is low; the
// req_ ports carry its fields. Every request gives exactly one response: a
// one-cycle pulse on rsp_valid with rsp_tag_out, rsp_map_word and rsp_was_hit.
// The receiver cannot stall; a response is simply present for that one cycle.
// One request is worked at a time, and busy is high until its response shows.
// Source requests, null loads, null or empty stores and unknown kinds answer
// from the execute state; a readout waits for the bitmap and hit flag reads;
// a compare reads and rewrites one bitmap word per tracked tag; a load stops
// at the first tagged byte. The next request can be taken at the edge that
// takes the response. The single-port shadow memory paces loads and stores:
// a store writes one byte per cycle, a load reads one byte and checks it in
// the next. After reset a clearing pass zeroes all memories, one entry per
// cycle, with busy held high; no request is taken until it ends.
module shadow_taint_tag_tracker
   import stt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [63:0] req_address,
   input  logic [4:0]  req_access_size,
   input  logic [15:0] req_tag_a,
   input  logic [15:0] req_tag_b,
   input  logic [7:0]  req_compare_id,
   input  logic [15:0] req_src_offset,
   input  logic [5:0]  req_word_index,
   output logic        rsp_valid,
   output logic [15:0] rsp_tag_out,
   output logic [63:0] rsp_map_word,
   output logic        rsp_was_hit
);

`include "shadow_taint_tag_tracker_assert.svh"

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_LOAD_RD,
      S_LOAD_CHK,
      S_STORE,
      S_CMP_RD,
      S_CMP_WR,
      S_MAP_WAIT
   } state_type;

   state_type         state_ff;
   logic [2:0]        kind_ff;
   logic [63:0]       addr_ff;
   logic [4:0]        size_ff;
   logic [15:0]       tag_a_ff;
   logic [15:0]       tag_b_ff;
   logic [7:0]        site_ff;
   logic [15:0]       offset_ff;
   logic [5:0]        word_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              phase_ff;
   logic              rsp_valid_ff;
   logic [15:0]       rsp_tag_ff;
   logic [63:0]       rsp_map_ff;
   logic              rsp_hit_ff;

   logic [CLR_W-1:0]  clr_ff;
   logic              clr_done_ff;

   mem_cmd_type       cmd;
   mem_rsp_type       mrsp;

   logic [CNT_W-1:0]  size_clamp;
   logic              site_ok;
   logic              last_byte;
   logic [TAG_AW-1:0] byte_slot;
   logic [15:0]       cmp_tag;
   logic [15:0]       cmp_off;
   logic              cmp_ok;
   logic [MAP_AW-1:0] cmp_waddr;
   logic [MAP_AW-1:0] rd_waddr;
   logic              src_ok;

   assign size_clamp = (32'(size_ff) > MAX_ACCESS_BYTES) ? CNT_W'(MAX_ACCESS_BYTES)
                                                          : CNT_W'(size_ff);
   assign site_ok    = 32'(site_ff) < COMPARE_SITES;
   assign last_byte  = CNT_W'(idx_ff + 1'b1) == cnt_ff;
   assign byte_slot  = addr_ff[TAG_AW-1:0] + TAG_AW'(idx_ff);
   assign cmp_tag    = phase_ff ? tag_b_ff : tag_a_ff;
   assign cmp_off    = cmp_tag - 16'd1;
   assign cmp_ok     = (cmp_tag != 16'd0) && (32'(cmp_off) < TRACKED_OFFSETS);
   assign cmp_waddr  = MAP_AW'(32'(site_ff) * WORDS_PER_SITE + 32'(cmp_off[15:6]));
   assign rd_waddr   = MAP_AW'(32'(site_ff) * WORDS_PER_SITE + 32'(word_ff));
   assign src_ok     = (offset_ff <= SOURCE_OFFSET_LIMIT)
                       && ((addr_ff - 64'(offset_ff)) != 64'd0);

   assign busy = (state_ff != S_IDLE) || !clr_done_ff;

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clr_done_ff <= 1'b0;
      end else if (!clr_done_ff) begin
         if (32'(clr_ff) == CLR_COUNT - 1) begin
            clr_done_ff <= 1'b1;
         end else begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   always_comb begin
      cmd = '0;
      if (!clr_done_ff) begin
         cmd.tag_we   = 32'(clr_ff) < SHADOW_ENTRIES;
         cmd.tag_addr = TAG_AW'(clr_ff);
         cmd.map_we   = 32'(clr_ff) < MAP_WORDS;
         cmd.map_addr = MAP_AW'(clr_ff);
         cmd.hit_we   = 32'(clr_ff) < COMPARE_SITES;
         cmd.hit_addr = SITE_AW'(clr_ff);
      end else begin
         unique case (state_ff)
            S_EXEC: begin
               cmd.tag_addr  = addr_ff[TAG_AW-1:0];
               cmd.tag_wdata = offset_ff + 16'd1;
               cmd.tag_we    = (kind_ff == KIND_SOURCE) && src_ok;
               cmd.hit_addr  = SITE_AW'(site_ff);
               cmd.hit_wdata = 1'b1;
               cmd.hit_we    = (kind_ff == KIND_COMPARE) && site_ok;
               cmd.map_addr  = rd_waddr;
            end
            S_LOAD_RD: begin
               cmd.tag_addr = byte_slot;
            end
            S_STORE: begin
               cmd.tag_addr  = byte_slot;
               cmd.tag_wdata = tag_a_ff;
               cmd.tag_we    = 1'b1;
            end
            S_CMP_RD: begin
               cmd.map_addr = cmp_waddr;
            end
            S_CMP_WR: begin
               cmd.map_addr  = cmp_waddr;
               cmd.map_wdata = mrsp.map_rdata | (64'd1 << cmp_off[5:0]);
               cmd.map_we    = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   stt_mem_bank u_mem (
      .clock (clock),
      .cmd   (cmd),
      .rsp   (mrsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start && clr_done_ff) begin
                  kind_ff   <= req_kind;
                  addr_ff   <= req_address;
                  size_ff   <= req_access_size;
                  tag_a_ff  <= req_tag_a;
                  tag_b_ff  <= req_tag_b;
                  site_ff   <= req_compare_id;
                  offset_ff <= req_src_offset;
                  word_ff   <= req_word_index;
                  state_ff  <= S_EXEC;
               end
            end
            S_EXEC: begin
               rsp_tag_ff <= '0;
               rsp_map_ff <= '0;
               rsp_hit_ff <= 1'b0;
               idx_ff     <= '0;
               phase_ff   <= 1'b0;
               priority if (kind_ff == KIND_LOAD && addr_ff != 64'd0) begin
                  cnt_ff   <= (size_clamp == '0) ? CNT_W'(1) : size_clamp;
                  state_ff <= S_LOAD_RD;
               end else if (kind_ff == KIND_STORE && addr_ff != 64'd0
                            && size_clamp != '0) begin
                  cnt_ff   <= size_clamp;
                  state_ff <= S_STORE;
               end else if (kind_ff == KIND_COMPARE && site_ok) begin
                  state_ff <= S_CMP_RD;
               end else if (kind_ff == KIND_READOUT && site_ok) begin
                  state_ff <= S_MAP_WAIT;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_LOAD_RD: begin
               state_ff <= S_LOAD_CHK;
            end
            S_LOAD_CHK: begin
               if (mrsp.tag_rdata != 16'd0) begin
                  rsp_tag_ff   <= mrsp.tag_rdata;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else if (last_byte) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_LOAD_RD;
               end
            end
            S_STORE: begin
               if (last_byte) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_CMP_RD: begin
               priority if (cmp_ok) begin
                  state_ff <= S_CMP_WR;
               end else if (phase_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  phase_ff <= 1'b1;
               end
            end
            S_CMP_WR: begin
               if (phase_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  phase_ff <= 1'b1;
                  state_ff <= S_CMP_RD;
               end
            end
            S_MAP_WAIT: begin
               rsp_map_ff   <= (32'(word_ff) < WORDS_PER_SITE) ? mrsp.map_rdata : 64'd0;
               rsp_hit_ff   <= mrsp.hit_rdata;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_tag_out  = rsp_tag_ff;
   assign rsp_map_word = rsp_map_ff;
   assign rsp_was_hit  = rsp_hit_ff;

   `STT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy,
                    "accepted request not busy")
   `STT_ASSERT_NOW(a_clear_quiet, clock, reset, !clr_done_ff, !rsp_valid_ff,
                   "response during clear")
   `STT_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid_ff, !rsp_valid_ff,
                    "response longer than a cycle")
   `STT_ASSERT_NOW(a_tag_only_load, clock, reset, rsp_valid_ff && kind_ff != KIND_LOAD,
                   rsp_tag_ff == 16'd0, "tag on non-load response")
   `STT_ASSERT_NOW(a_idx_range, clock, reset,
                   state_ff == S_STORE || state_ff == S_LOAD_RD, idx_ff < cnt_ff,
                   "byte index past count")

endmodule

>>> dv/tb_shadow_taint_tag_tracker.sv
// testbench for the taint tag tracker: directed and random requests against a predictor
module tb_shadow_taint_tag_tracker;
   import stt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] KIND_RESERVED = 3'd5;
   localparam logic [2:0] KIND_LAST     = 3'd7;
   localparam int         DRAIN_CYCLES  = 40;
   localparam int         RANDOM_COUNT  = 1625;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] address;
      logic [4:0]  access_size;
      logic [15:0] tag_a;
      logic [15:0] tag_b;
      logic [7:0]  compare_id;
      logic [15:0] src_offset;
      logic [5:0]  word_index;
   } tracker_req_type;

   typedef struct packed {
      logic [15:0] tag_out;
      logic [63:0] map_word;
      logic        was_hit;
   } tracker_rsp_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_kind;
   logic [63:0] req_address;
   logic [4:0]  req_access_size;
   logic [15:0] req_tag_a;
   logic [15:0] req_tag_b;
   logic [7:0]  req_compare_id;
   logic [15:0] req_src_offset;
   logic [5:0]  req_word_index;
   logic        rsp_valid;
   logic [15:0] rsp_tag_out;
   logic [63:0] rsp_map_word;
   logic        rsp_was_hit;

   logic [15:0] shadow_copy [SHADOW_ENTRIES];
   logic [63:0] bitmap_copy [MAP_WORDS];
   logic        hit_copy [COMPARE_SITES];

   tracker_rsp_type awaited_responses [$];
   int              fail_count;
   bit              gaps_enabled;
   logic [63:0]     window_base;

   shadow_taint_tag_tracker DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_address      (req_address),
      .req_access_size  (req_access_size),
      .req_tag_a        (req_tag_a),
      .req_tag_b        (req_tag_b),
      .req_compare_id   (req_compare_id),
      .req_src_offset   (req_src_offset),
      .req_word_index   (req_word_index),
      .rsp_valid        (rsp_valid),
      .rsp_tag_out      (rsp_tag_out),
      .rsp_map_word     (rsp_map_word),
      .rsp_was_hit      (rsp_was_hit)
   );

   always #1ns clock = ~clock;

   initial begin
      #2_000_000ns;
      $display("simulation failed");
      $finish;
   end

   function automatic void mark_offset_bit(input int unsigned site, input logic [15:0] tag);
      int unsigned off;
      off = 32'(tag) - 32'd1;
      if (tag != 16'd0 && off < TRACKED_OFFSETS)
         bitmap_copy[MAP_AW'(site * WORDS_PER_SITE + off / 64)][off[5:0]] = 1'b1;
   endfunction

   function automatic tracker_rsp_type track_taint(input tracker_req_type r);
      tracker_rsp_type o;
      int unsigned n;
      int unsigned i;
      logic [63:0] a;
      o = '0;
      n = (32'(r.access_size) > MAX_ACCESS_BYTES) ? MAX_ACCESS_BYTES : 32'(r.access_size);
      case (r.kind)
         KIND_SOURCE: begin
            if (r.src_offset <= SOURCE_OFFSET_LIMIT && r.address - 64'(r.src_offset) != 0)
               shadow_copy[r.address[TAG_AW-1:0]] = r.src_offset + 16'd1;
         end
         KIND_LOAD: begin
            if (r.address != 0) begin
               if (n == 0) n = 1;
               for (i = 0; i < n && o.tag_out == 16'd0; i++) begin
                  a = r.address + 64'(i);
                  o.tag_out = shadow_copy[a[TAG_AW-1:0]];
               end
            end
         end
         KIND_STORE: begin
            if (r.address != 0)
               for (i = 0; i < n; i++) begin
                  a = r.address + 64'(i);
                  shadow_copy[a[TAG_AW-1:0]] = r.tag_a;
               end
         end
         KIND_COMPARE: begin
            if (r.compare_id < COMPARE_SITES) begin
               hit_copy[r.compare_id] = 1'b1;
               mark_offset_bit(32'(r.compare_id), r.tag_a);
               mark_offset_bit(32'(r.compare_id), r.tag_b);
            end
         end
         KIND_READOUT: begin
            if (r.compare_id < COMPARE_SITES) begin
               o.was_hit = hit_copy[r.compare_id];
               if (r.word_index < WORDS_PER_SITE)
                  o.map_word = bitmap_copy[MAP_AW'(32'(r.compare_id) * WORDS_PER_SITE
                                                   + 32'(r.word_index))];
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic tracker_req_type make_request(input logic [2:0] kind,
         input logic [63:0] address, input logic [4:0] size, input logic [15:0] tag_a,
         input logic [15:0] tag_b, input logic [7:0] site, input logic [15:0] offset,
         input logic [5:0] word);
      tracker_req_type r;
      r.kind = kind;
      r.address = address;
      r.access_size = size;
      r.tag_a = tag_a;
      r.tag_b = tag_b;
      r.compare_id = site;
      r.src_offset = offset;
      r.word_index = word;
      return r;
   endfunction

   task automatic issue_request(input tracker_req_type r);
      int unsigned gap;
      gap = gaps_enabled ? $urandom_range(0, 16) : 0;
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind <= r.kind;
      req_address <= r.address;
      req_access_size <= r.access_size;
      req_tag_a <= r.tag_a;
      req_tag_b <= r.tag_b;
      req_compare_id <= r.compare_id;
      req_src_offset <= r.src_offset;
      req_word_index <= r.word_index;
      start <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      awaited_responses.push_back(track_taint(r));
   endtask

   task automatic wait_for_quiet();
      @(negedge clock);
      start <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
   endtask

   // tagging, the source limits and load sizes
   task automatic test_source_and_load();
      issue_request(make_request(KIND_SOURCE, 64'h1000_0000_0000_0010, 5'd0, 16'd0, 16'd0,
                                 8'd0, 16'd0, 6'd0));
      issue_request(make_request(KIND_LOAD, 64'h0000_0000_0000_0010, 5'd1, 16'd0, 16'd0,
                                 8'd0, 16'd0, 6'd0));
      issue_request(make_request(KIND_SOURCE, 64'h20, 5'd0, 16'd0, 16'd0, 8'd0,
                                 16'd65534, 6'd0));
      issue_request(make_request(KIND_SOURCE, 64'h21, 5'd0, 16'd0, 16'd0, 8'd0,
                                 16'hFFFF, 6'd0));
      issue_request(make_request(KIND_LOAD, 64'h20, 5'd2, 16'd0, 16'd0, 8'd0, 16'd0, 6'd0));
      issue_request(make_request(KIND_SOURCE, 64'd7, 5'd0, 16'd0, 16'd0, 8'd0, 16'd7, 6'd0));
      issue_request(make_request(KIND_LOAD, 64'd7, 5'd1, 16'd0, 16'd0, 8'd0, 16'd0, 6'd0));
      issue_request(make_request(KIND_LOAD, 64'd0, 5'd4, 16'd0, 16'd0, 8'd0, 16'd0, 6'd0));
      issue_request(make_request(KIND_LOAD, 64'h21, 5'd0, 16'd0, 16'd0, 8'd0, 16'd0, 6'd0));
   endtask

   // stores: empty, null, saturated size across the address wrap, untaint
   task automatic test_store();
      issue_request(make_request(KIND_STORE, 64'h30, 5'd0, 16'd5, 16'd0, 8'd0, 16'd0, 6'd0));
      issue_request(make_request(KIND_LOAD, 64'h30, 5'd1, 16'd0, 16'd0, 8'd0, 16'd0, 6'd0));
      issue_request(make_request(KIND_STORE, 64'd0, 5'd16, 16'd9, 16'd0, 8'd0, 16'd0, 6'd0));
      issue_request(make_request(KIND_STORE, 64'hFFFF_FFFF_FFFF_FFFA, 5'd31, 16'hFFFF,
                                 16'hFFFF, 8'hFF, 16'hFFFF, 6'h3F));
      issue_request(make_request(KIND_LOAD, 64'hFFFF_FFFF_FFFF_FFF8, 5'd31, 16'd0, 16'd0,
                                 8'd0, 16'd0, 6'd0));
      issue_request(make_request(KIND_LOAD, 64'd3, 5'd0, 16'd0, 16'd0, 8'd0, 16'd0, 6'd0));
      issue_request(make_request(KIND_STORE, 64'd5, 5'd1, 16'd0, 16'd0, 8'd0, 16'd0, 6'd0));
      issue_request(make_request(KIND_LOAD, 64'd4, 5'd3, 16'd0, 16'd0, 8'd0, 16'd0, 6'd0));
   endtask

   // compare marking, tracked and untracked offsets, readouts and reserved kinds
   task automatic test_compare_readout();
      logic [2:0] k;
      issue_request(make_request(KIND_COMPARE, 64'd0, 5'd0, 16'd4096, 16'd4097, 8'hFF,
                                 16'd0, 6'd0));
      issue_request(make_request(KIND_READOUT, 64'd0, 5'd0, 16'd0, 16'd0, 8'hFF, 16'd0,
                                 6'h3F));
      issue_request(make_request(KIND_COMPARE, 64'd0, 5'd0, 16'd0, 16'hFFFF, 8'd3,
                                 16'd0, 6'd0));
      issue_request(make_request(KIND_COMPARE, 64'd0, 5'd0, 16'd1, 16'd65, 8'd3, 16'd0, 6'd0));
      issue_request(make_request(KIND_READOUT, 64'd0, 5'd0, 16'd0, 16'd0, 8'd3, 16'd0, 6'd0));
      issue_request(make_request(KIND_READOUT, 64'd0, 5'd0, 16'd0, 16'd0, 8'd3, 16'd0, 6'd1));
      issue_request(make_request(KIND_READOUT, 64'd0, 5'd0, 16'd0, 16'd0, 8'd200, 16'd0,
                                 6'd0));
      for (k = KIND_RESERVED; k <= KIND_LAST && k >= KIND_RESERVED; k++)
         issue_request(make_request(k, 64'h20, 5'd16, 16'd1, 16'd2, 8'd3, 16'd4, 6'd0));
   endtask

   function automatic tracker_req_type draw_request();
      tracker_req_type r;
      int unsigned pick;
      r.address = {$urandom, $urandom};
      r.access_size = 5'($urandom);
      r.tag_a = 16'($urandom);
      r.tag_b = 16'($urandom);
      r.compare_id = 8'($urandom);
      r.src_offset = 16'($urandom);
      r.word_index = 6'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 25)      r.kind = KIND_SOURCE;
      else if (pick < 50) r.kind = KIND_LOAD;
      else if (pick < 65) r.kind = KIND_STORE;
      else if (pick < 85) r.kind = KIND_COMPARE;
      else if (pick < 97) r.kind = KIND_READOUT;
      else                r.kind = 3'($urandom_range(KIND_RESERVED, KIND_LAST));
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         r.address = window_base + 64'($urandom_range(0, 63));
         r.src_offset = 16'($urandom_range(0, 299));
         r.access_size = 5'($urandom_range(0, 17));
         if (r.kind != KIND_STORE || $urandom_range(0, 1) == 0)
            r.tag_a = 16'($urandom_range(0, 300));
         r.tag_b = 16'($urandom_range(0, 300));
         r.compare_id = 8'($urandom_range(0, 7));
         r.word_index = 6'($urandom_range(0, 4));
      end else if (pick < 89) begin
         r.address = '0;
      end else if (pick < 93) begin
         r.address = 64'(r.src_offset);
      end else if (pick < 97) begin
         r.address = '1 - 64'($urandom_range(0, 20));
      end
      return r;
   endfunction

   // mostly tag, load and compare traffic inside a moving address window
   task automatic test_random_traffic();
      int n;
      for (n = 0; n < RANDOM_COUNT; n++) begin
         if (n % 256 == 0) begin
            window_base = {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0) window_base = '1 - 64'($urandom_range(0, 40));
         end
         if (n % 64 == 0) gaps_enabled = $urandom_range(0, 3) != 0;
         if (n == RANDOM_COUNT / 2) wait_for_quiet();
         issue_request(draw_request());
      end
   endtask

   always @(posedge clock) begin
      tracker_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: unexpected response, expected none actual %h %h %b", $time,
                     rsp_tag_out, rsp_map_word, rsp_was_hit);
            fail_count++;
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_tag_out !== want.tag_out) begin
               $display("%0t: tag_out expected %h actual %h", $time, want.tag_out,
                        rsp_tag_out);
               fail_count++;
            end
            if (rsp_map_word !== want.map_word) begin
               $display("%0t: map_word expected %h actual %h", $time, want.map_word,
                        rsp_map_word);
               fail_count++;
            end
            if (rsp_was_hit !== want.was_hit) begin
               $display("%0t: was_hit expected %b actual %b", $time, want.was_hit,
                        rsp_was_hit);
               fail_count++;
            end
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_kind = '0;
      req_address = '0;
      req_access_size = '0;
      req_tag_a = '0;
      req_tag_b = '0;
      req_compare_id = '0;
      req_src_offset = '0;
      req_word_index = '0;
      fail_count = 0;
      gaps_enabled = 1'b1;
      window_base = '0;
      foreach (shadow_copy[i]) shadow_copy[i] = '0;
      foreach (bitmap_copy[i]) bitmap_copy[i] = '0;
      foreach (hit_copy[i]) hit_copy[i] = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_source_and_load();
      test_store();
      test_compare_readout();
      test_random_traffic();
      wait_for_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/stt_pkg.sv
hw/rtl/stt_mem_bank.sv
hw/rtl/shadow_taint_tag_tracker.sv
dv/tb_shadow_taint_tag_tracker.sv
